### sv/fba_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fba_pkg
// Shared types and codes for the frame bitmap allocator: request and response
// items, result status codes, and the controller/datapath command and status.
// ----------------------------------------------------------------------------
package fba_pkg;

    localparam int FRAME_W     = 12;
    localparam int STATUS_W    = 2;
    localparam int QUOT_W      = 10;
    localparam int RECIP_SHIFT = 24;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOTHING = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

    localparam logic [1:0] RES_NOTHING = 2'd0;
    localparam logic [1:0] RES_FULL    = 2'd1;
    localparam logic [1:0] RES_ALLOC   = 2'd2;
    localparam logic [1:0] RES_FREE    = 2'd3;

    typedef struct packed {
        logic               opcode;
        logic [FRAME_W-1:0] current_frame;
        logic               kernel_page;
        logic               write_access;
    } fba_in_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [FRAME_W-1:0]  frame_out;
        logic                present_flag;
        logic                writable_flag;
        logic                user_flag;
    } fba_out_t;

    typedef struct packed {
        logic       clr_write;
        logic       accept;
        logic       scan_next;
        logic       hit_write;
        logic       div;
        logic       rem;
        logic       free_write;
        logic       set_res;
        logic [1:0] res_kind;
        logic       out_load;
    } fba_cmd_t;

    typedef struct packed {
        logic idx_last;
        logic in_alloc;
        logic in_cur_zero;
        logic words_none;
        logic word_full;
        logic q_in_range;
        logic out_free;
    } fba_sts_t;

endpackage

### sv/fba_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fba_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module fba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### sv/fba_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fba_dp
// Datapath: bitmap memory, word counter, lowest-free-bit search, frame
// number split for frees, result staging and the output register.
// ----------------------------------------------------------------------------
module fba_dp
    import fba_pkg::*;
#(
    parameter int FRAME_COUNT = 4096,
    parameter int WORD_BITS   = 32
) (
    input  logic     clk,
    input  logic     rst_n,
    input  fba_in_t  req,
    input  fba_cmd_t cmd,
    output fba_sts_t sts,
    input  logic     rsp_stall,
    output logic     rsp_valid,
    output fba_out_t rsp
);

    localparam int WORDS_USED = FRAME_COUNT / WORD_BITS;
    localparam int DEPTH      = (WORDS_USED > 0) ? WORDS_USED : 1;
    localparam int AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int BW         = $clog2(WORD_BITS);
    localparam int FW         = (AW + BW + 1 > FRAME_W) ? AW + BW + 1 : FRAME_W;
    localparam int RECIP      = ((1 << RECIP_SHIFT) + WORD_BITS - 1) / WORD_BITS;
    localparam int RECIP_W    = RECIP_SHIFT + 1 - BW;
    localparam int PROD_W     = FRAME_W + RECIP_W;

    logic [AW-1:0]     idx_reg, idx_next;
    logic [QUOT_W-1:0] quot_reg, quot_next;
    logic [BW-1:0]     rem_reg, rem_next;
    fba_in_t           req_reg;
    fba_out_t          res_reg, res_next;
    fba_out_t          out_reg;
    logic              out_valid_reg, out_valid_next;

    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [WORD_BITS-1:0] ram_wdata;
    logic [AW-1:0]        ram_raddr;
    logic [WORD_BITS-1:0] ram_rdata;

    logic [BW-1:0]        zero_pos;
    logic [WORD_BITS-1:0] zero_mask;
    logic [FW-1:0]        frame_full;
    logic [PROD_W-1:0]    quot_prod;
    logic [FRAME_W-1:0]   quot_back;
    logic [FRAME_W-1:0]   rem_diff;

    fba_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_bitmap (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        zero_pos = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--)
        begin
            if (!ram_rdata[b])
            begin
                zero_pos = BW'(b);
            end
        end
    end

    assign zero_mask  = ~ram_rdata & (ram_rdata + WORD_BITS'(1));
    assign frame_full = FW'(idx_reg) * FW'(WORD_BITS) + FW'(zero_pos);

    assign quot_prod = PROD_W'(req_reg.current_frame) * PROD_W'(RECIP);
    assign quot_next = QUOT_W'(quot_prod >> RECIP_SHIFT);
    assign quot_back = FRAME_W'(quot_reg) * FRAME_W'(WORD_BITS);
    assign rem_diff  = req_reg.current_frame - quot_back;
    assign rem_next  = rem_diff[BW-1:0];

    assign ram_we    = cmd.clr_write | cmd.hit_write | cmd.free_write;
    assign ram_waddr = cmd.free_write ? AW'(quot_reg) : idx_reg;

    always_comb
    begin
        if (cmd.clr_write)
        begin
            ram_wdata = '0;
        end
        else if (cmd.hit_write)
        begin
            ram_wdata = ram_rdata | zero_mask;
        end
        else
        begin
            ram_wdata = ram_rdata & ~(WORD_BITS'(1) << rem_reg);
        end
    end

    always_comb
    begin
        if (cmd.accept)
        begin
            ram_raddr = '0;
        end
        else if (cmd.rem)
        begin
            ram_raddr = AW'(quot_reg);
        end
        else
        begin
            ram_raddr = idx_reg + AW'(1);
        end
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.accept)
        begin
            idx_next = '0;
        end
        else if (cmd.clr_write || cmd.scan_next)
        begin
            idx_next = idx_reg + AW'(1);
        end
    end

    always_comb
    begin
        res_next = res_reg;
        if (cmd.set_res)
        begin
            res_next = '0;
            case (cmd.res_kind)
                RES_NOTHING: res_next.status = ST_NOTHING;
                RES_FULL:    res_next.status = ST_FULL;
                RES_ALLOC:
                begin
                    res_next.status        = ST_DONE;
                    res_next.frame_out     = frame_full[FRAME_W-1:0];
                    res_next.present_flag  = 1'b1;
                    res_next.writable_flag = req_reg.write_access;
                    res_next.user_flag     = ~req_reg.kernel_page;
                end
                RES_FREE:    res_next.status = ST_DONE;
                default:     res_next.status = ST_NOTHING;
            endcase
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            req_reg <= req;
        end
        if (cmd.div)
        begin
            quot_reg <= quot_next;
        end
        if (cmd.rem)
        begin
            rem_reg <= rem_next;
        end
        res_reg <= res_next;
        if (cmd.out_load)
        begin
            out_reg <= res_reg;
        end
    end

    assign sts.idx_last    = (idx_reg == AW'(DEPTH - 1));
    assign sts.in_alloc    = (req.opcode == OP_ALLOC);
    assign sts.in_cur_zero = (req.current_frame == '0);
    assign sts.words_none  = (WORDS_USED == 0);
    assign sts.word_full   = (ram_rdata == '1);
    assign sts.q_in_range  = (32'(quot_reg) < 32'(WORDS_USED));
    assign sts.out_free    = ~out_valid_reg | ~rsp_stall;

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

endmodule

### sv/fba_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fba_ctrl
// Controller: clearing pass after reset, request decode, word scan for
// allocation, read-modify-write for frees, and hand-off to the output.
// ----------------------------------------------------------------------------
module fba_ctrl
    import fba_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_stall,
    input  fba_sts_t sts,
    output fba_cmd_t cmd
);

    localparam logic [2:0] S_CLEAR   = 3'd0;
    localparam logic [2:0] S_IDLE    = 3'd1;
    localparam logic [2:0] S_SCAN    = 3'd2;
    localparam logic [2:0] S_DIV     = 3'd3;
    localparam logic [2:0] S_REM     = 3'd4;
    localparam logic [2:0] S_FREE_WB = 3'd5;
    localparam logic [2:0] S_POST    = 3'd6;

    logic [2:0] state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_stall  = 1'b1;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_write = 1'b1;
                if (sts.idx_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                begin
                    cmd.accept = 1'b1;
                    if (sts.in_alloc != sts.in_cur_zero)
                    begin
                        cmd.set_res  = 1'b1;
                        cmd.res_kind = RES_NOTHING;
                        state_next   = S_POST;
                    end
                    else if (sts.in_alloc && sts.words_none)
                    begin
                        cmd.set_res  = 1'b1;
                        cmd.res_kind = RES_FULL;
                        state_next   = S_POST;
                    end
                    else if (sts.in_alloc)
                    begin
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        state_next = S_DIV;
                    end
                end
            end
            S_SCAN:
            begin
                if (!sts.word_full)
                begin
                    cmd.hit_write = 1'b1;
                    cmd.set_res   = 1'b1;
                    cmd.res_kind  = RES_ALLOC;
                    state_next    = S_POST;
                end
                else if (sts.idx_last)
                begin
                    cmd.set_res  = 1'b1;
                    cmd.res_kind = RES_FULL;
                    state_next   = S_POST;
                end
                else
                begin
                    cmd.scan_next = 1'b1;
                end
            end
            S_DIV:
            begin
                cmd.div    = 1'b1;
                state_next = S_REM;
            end
            S_REM:
            begin
                cmd.rem = 1'b1;
                if (sts.q_in_range)
                begin
                    state_next = S_FREE_WB;
                end
                else
                begin
                    cmd.set_res  = 1'b1;
                    cmd.res_kind = RES_FREE;
                    state_next   = S_POST;
                end
            end
            S_FREE_WB:
            begin
                cmd.free_write = 1'b1;
                cmd.set_res    = 1'b1;
                cmd.res_kind   = RES_FREE;
                state_next     = S_POST;
            end
            S_POST:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### sv/frame_bitmap_allocator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_bitmap_allocator_core
// First-fit page frame allocator over a bitmap of used and free frames.
//
// Requests enter on req (req_valid/req_stall), one response item per request
// leaves on rsp (rsp_valid/rsp_stall). An item is taken on a clock edge with
// valid high and stall low.
// After reset the bitmap memory is swept to zero, one word per cycle, over
// all FRAME_COUNT / WORD_BITS words; req_stall stays high.
// One request is worked at a time. An allocation reads one bitmap word per
// cycle from the single memory read port until it finds a free bit. A free
// splits the frame number, reads and rewrites its word. The response sits in
// an output register; while rsp_stall is high it holds, and the next request
// is still accepted and worked up to its result.
// ----------------------------------------------------------------------------
module frame_bitmap_allocator_core
    import fba_pkg::*;
#(
    parameter int FRAME_COUNT = 4096,
    parameter int WORD_BITS   = 32
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_stall,
    input  fba_in_t  req,
    output logic     rsp_valid,
    input  logic     rsp_stall,
    output fba_out_t rsp
);

    fba_cmd_t cmd;
    fba_sts_t sts;

    fba_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    fba_dp #(
        .FRAME_COUNT (FRAME_COUNT),
        .WORD_BITS   (WORD_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .sts       (sts),
        .rsp_stall (rsp_stall),
        .rsp_valid (rsp_valid),
        .rsp       (rsp)
    );

endmodule

### dv/frame_bitmap_allocator_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_bitmap_allocator_core_tb
// Self-checking bench for the first-fit frame bitmap allocator. A local copy
// of the frame bitmap predicts every response as each request is taken; a
// checker compares responses field by field in order. Directed tests cover
// frame zero, the page-entry flags, no-op requests, frees and reuse, and a long
// receiver hold-off; random traffic then mixes well-formed alloc/free sequences
// with noise under random idling and back-pressure.
// ----------------------------------------------------------------------------
module frame_bitmap_allocator_core_tb;
    import fba_pkg::*;

    localparam int  FRAME_COUNT  = 4096;
    localparam int  WORD_BITS    = 32;
    localparam int  WORD_COUNT   = FRAME_COUNT / WORD_BITS;
    localparam int  RANDOM_ITEMS = 400;
    localparam int  CYCLE_LIMIT  = 2000000;
    localparam int  IDLE_PCT     = 27;

    logic     clk = 1'b0;
    logic     rst_n;
    logic     req_valid;
    logic     req_stall;
    fba_in_t  req;
    logic     rsp_valid;
    logic     rsp_stall;
    fba_out_t rsp;

    logic [WORD_BITS-1:0] frame_words [WORD_COUNT];
    fba_out_t             expected_rsp_q[$];
    logic [FRAME_W-1:0]   held_frames[$];

    bit req_idle_on;
    bit rsp_idle_on;
    int hold_off_left;
    int error_count;
    int cycle_count = 0;
    int alloc_count;
    int free_count;
    int full_count;
    int noop_count;

    frame_bitmap_allocator_core #(
        .FRAME_COUNT (FRAME_COUNT),
        .WORD_BITS   (WORD_BITS)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d responses outstanding",
                     cycle_count, expected_rsp_q.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    function automatic fba_in_t make_req(logic op, logic [FRAME_W-1:0] cur,
                                         logic kern, logic wr);
        fba_in_t r;
        r.opcode        = op;
        r.current_frame = cur;
        r.kernel_page   = kern;
        r.write_access  = wr;
        return r;
    endfunction

    function automatic fba_out_t predict_response(fba_in_t item);
        fba_out_t r;
        bit       found;
        int       hit;
        r     = '0;
        found = 1'b0;
        hit   = 0;
        if (item.opcode == OP_ALLOC)
        begin
            if (item.current_frame != '0)
                r.status = ST_NOTHING;
            else
            begin
                for (int w = 0; w < WORD_COUNT; w++)
                    if (!found && frame_words[w] != '1)
                        for (int b = 0; b < WORD_BITS; b++)
                            if (!found && !frame_words[w][b])
                            begin
                                found = 1'b1;
                                hit   = w * WORD_BITS + b;
                            end
                if (!found)
                    r.status = ST_FULL;
                else
                begin
                    frame_words[hit / WORD_BITS][hit % WORD_BITS] = 1'b1;
                    r.status        = ST_DONE;
                    r.frame_out     = hit[FRAME_W-1:0];
                    r.present_flag  = 1'b1;
                    r.writable_flag = item.write_access;
                    r.user_flag     = ~item.kernel_page;
                end
            end
        end
        else
        begin
            if (item.current_frame == '0)
                r.status = ST_NOTHING;
            else
            begin
                if (int'(item.current_frame) < FRAME_COUNT)
                    frame_words[item.current_frame / WORD_BITS]
                               [item.current_frame % WORD_BITS] = 1'b0;
                r.status = ST_DONE;
            end
        end
        return r;
    endfunction

    task automatic update_held(fba_in_t item, fba_out_t res);
        int idx;
        idx = -1;
        if (item.opcode == OP_ALLOC && res.status == ST_DONE && res.frame_out != '0)
            held_frames.push_back(res.frame_out);
        else if (item.opcode == OP_FREE && res.status == ST_DONE)
        begin
            foreach (held_frames[i])
                if (idx < 0 && held_frames[i] == item.current_frame)
                    idx = i;
            if (idx >= 0)
                held_frames.delete(idx);
        end
    endtask

    task automatic send_request(input fba_in_t item, output fba_out_t predicted);
        if (req_idle_on)
            while ($urandom_range(0, 99) < IDLE_PCT)
            begin
                req_valid <= 1'b0;
                @(posedge clk);
            end
        req_valid <= 1'b1;
        req       <= item;
        do
            @(posedge clk);
        while (req_stall);
        predicted = predict_response(item);
        expected_rsp_q.push_back(predicted);
        update_held(item, predicted);
        if (predicted.status == ST_FULL)
            full_count++;
        else if (predicted.status == ST_NOTHING)
            noop_count++;
        else if (item.opcode == OP_ALLOC)
            alloc_count++;
        else
            free_count++;
    endtask

    task automatic send(logic op, logic [FRAME_W-1:0] cur, logic kern, logic wr);
        fba_out_t predicted;
        send_request(make_req(op, cur, kern, wr), predicted);
    endtask

    task automatic wait_for_results();
        req_valid <= 1'b0;
        while (expected_rsp_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic check_response(fba_out_t got);
        fba_out_t want;
        if (expected_rsp_q.size() == 0)
        begin
            error_count++;
            if (error_count <= 10)
                $display("ERROR: unexpected response status=%0d frame=%0d p=%b w=%b u=%b",
                         got.status, got.frame_out, got.present_flag,
                         got.writable_flag, got.user_flag);
            return;
        end
        want = expected_rsp_q.pop_front();
        if (got.status !== want.status || got.frame_out !== want.frame_out ||
            got.present_flag !== want.present_flag ||
            got.writable_flag !== want.writable_flag ||
            got.user_flag !== want.user_flag)
        begin
            error_count++;
            if (error_count <= 10)
            begin
                $display("ERROR: mismatch exp status=%0d frame=%0d p=%b w=%b u=%b",
                         want.status, want.frame_out, want.present_flag,
                         want.writable_flag, want.user_flag);
                $display("                act status=%0d frame=%0d p=%b w=%b u=%b",
                         got.status, got.frame_out, got.present_flag,
                         got.writable_flag, got.user_flag);
            end
        end
    endtask

    initial
    begin
        rsp_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_valid && !rsp_stall)
                check_response(rsp);
            if (hold_off_left > 0)
            begin
                hold_off_left = hold_off_left - 1;
                rsp_stall <= 1'b1;
            end
            else
                rsp_stall <= rsp_idle_on && ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    task automatic test_frame_zero_and_flags();
        send(OP_ALLOC, '0, 1'b0, 1'b1);
        send(OP_ALLOC, '0, 1'b1, 1'b0);
        send(OP_ALLOC, '0, 1'b1, 1'b1);
        send(OP_ALLOC, '0, 1'b0, 1'b0);
    endtask

    task automatic test_noop_requests();
        send(OP_ALLOC, 12'hFFF, 1'b0, 1'b1);
        send(OP_ALLOC, 12'h001, 1'b1, 1'b0);
        send(OP_ALLOC, 12'h800, 1'b1, 1'b1);
        send(OP_FREE, '0, 1'b1, 1'b1);
        send(OP_FREE, '0, 1'b0, 1'b0);
    endtask

    task automatic test_free_and_reuse();
        send(OP_FREE, 12'd1, 1'b0, 1'b0);
        send(OP_ALLOC, '0, 1'b0, 1'b1);
        send(OP_FREE, 12'hFFF, 1'b1, 1'b1);
        send(OP_FREE, 12'h555, 1'b0, 1'b1);
        send(OP_FREE, 12'd3, 1'b0, 1'b0);
        send(OP_FREE, 12'd2, 1'b1, 1'b0);
        send(OP_ALLOC, '0, 1'b1, 1'b1);
        send(OP_ALLOC, '0, 1'b0, 1'b0);
        send(OP_ALLOC, '0, 1'b1, 1'b0);
        wait_for_results();
    endtask

    task automatic test_backpressure();
        hold_off_left = 300;
        send(OP_ALLOC, '0, 1'b0, 1'b1);
        send(OP_ALLOC, '0, 1'b1, 1'b1);
        send(OP_FREE, 12'd4, 1'b0, 1'b0);
        send(OP_ALLOC, '0, 1'b0, 1'b0);
        send(OP_ALLOC, 12'h0AA, 1'b0, 1'b0);
        send(OP_FREE, '0, 1'b1, 1'b0);
        send(OP_ALLOC, '0, 1'b1, 1'b0);
        send(OP_FREE, 12'd5, 1'b1, 1'b1);
        wait_for_results();
    endtask

    task automatic test_random_traffic();
        fba_in_t  item;
        fba_out_t predicted;
        int       sel;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == 120)
            begin
                req_idle_on = 1'b0;
                rsp_idle_on = 1'b0;
            end
            if (n == 200)
            begin
                req_idle_on = 1'b1;
                rsp_idle_on = 1'b1;
            end
            if (n == 260)
                wait_for_results();
            sel  = $urandom_range(0, 99);
            item = make_req(OP_ALLOC, '0, 1'($urandom_range(0, 1)),
                            1'($urandom_range(0, 1)));
            if (sel < 50)
                item.opcode = OP_ALLOC;
            else if (sel < 85 && held_frames.size() > 0)
            begin
                item.opcode        = OP_FREE;
                item.current_frame = held_frames[$urandom_range(0, held_frames.size() - 1)];
            end
            else
                case ($urandom_range(0, 2))
                    0: item.current_frame = FRAME_W'($urandom_range(1, FRAME_COUNT - 1));
                    1: item.opcode = OP_FREE;
                    default:
                    begin
                        item.opcode        = OP_FREE;
                        item.current_frame = FRAME_W'($urandom_range(1, FRAME_COUNT - 1));
                    end
                endcase
            send_request(item, predicted);
        end
        wait_for_results();
    endtask

    initial
    begin
        rst_n         = 1'b0;
        req_valid     = 1'b0;
        req           = '0;
        req_idle_on   = 1'b1;
        rsp_idle_on   = 1'b1;
        hold_off_left = 0;
        error_count   = 0;
        alloc_count   = 0;
        free_count    = 0;
        full_count    = 0;
        noop_count    = 0;
        foreach (frame_words[w])
            frame_words[w] = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_frame_zero_and_flags();
        test_noop_requests();
        test_free_and_reuse();
        test_backpressure();
        test_random_traffic();

        repeat (20) @(posedge clk);
        $display("Run covered %0d successful allocations, %0d frees, %0d full reports",
                 alloc_count, free_count, full_count);
        $display("and %0d no-op requests, with random idling and a long receiver hold-off.",
                 noop_count);
        if (error_count == 0 && expected_rsp_q.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

### files.f
sv/fba_pkg.sv
sv/fba_ram.sv
sv/fba_dp.sv
sv/fba_ctrl.sv
sv/frame_bitmap_allocator_core.sv
dv/frame_bitmap_allocator_core_tb.sv
